// File: hw/rtl/fbtc_pkg.sv
`default_nettype none
package fbtc_pkg;

  localparam int unsigned GLYPH_COUNT    = 128;
  localparam int unsigned MAX_GLYPH_ROWS = 32;
  localparam int unsigned GLYPH_WIDTH    = 8;
  localparam int unsigned STORE_DEPTH    = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int unsigned FONT_AW        = $clog2(STORE_DEPTH);
  localparam int unsigned GROW_W         = $clog2(MAX_GLYPH_ROWS);
  localparam int unsigned CODE_W         = $clog2(GLYPH_COUNT);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 3'd6;

  // pixel format codes
  localparam logic [1:0] PF_8  = 2'd0;
  localparam logic [1:0] PF_16 = 2'd1;
  localparam logic [1:0] PF_24 = 2'd2;
  localparam logic [1:0] PF_32 = 2'd3;

  localparam logic [1:0]  RST_PIXEL_FORMAT = PF_32;
  localparam logic [31:0] RST_FRAME_BASE   = 32'h0000_0000;
  localparam logic [15:0] RST_LINE_PITCH   = 16'd4096;
  localparam logic [13:0] RST_SCREEN_WIDTH = 14'd1024;
  localparam logic [5:0]  RST_GLYPH_HEIGHT = 6'd16;
  localparam logic [31:0] RST_FG_COLOR     = 32'hffff_ffff;
  localparam logic [31:0] RST_BG_COLOR     = 32'h0000_0000;

  typedef struct packed {
    logic        command;
    logic [7:0]  char_code;
    logic [11:0] font_address;
    logic [7:0]  font_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] row_address;
    logic [31:0] pixel_0;
    logic [31:0] pixel_1;
    logic [31:0] pixel_2;
    logic [31:0] pixel_3;
    logic [31:0] pixel_4;
    logic [31:0] pixel_5;
    logic [31:0] pixel_6;
    logic [31:0] pixel_7;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic font_write;
    logic capture;
    logic prep;
    logic mul_line;
    logic mul_pitch;
    logic base;
    logic load_row;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_newline;
    logic is_skip;
    logic row_last;
    logic load_ok;
  } ctrl_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/fbtc_ram.sv
`default_nettype none
module fbtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/fbtc_ctrl.sv
`default_nettype none
module fbtc_ctrl import fbtc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_command_i,
  output logic              in_stall_o,
  input  wire ctrl_status_t status_i,
  output ctrl_cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_BASE = 3'd4;
  localparam logic [2:0] S_ROW  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.font_write = accept && in_command_i;
    cmd_o.capture    = accept && !in_command_i;
    cmd_o.prep       = (state_q == S_PREP);
    cmd_o.mul_line   = (state_q == S_MUL1);
    cmd_o.mul_pitch  = (state_q == S_MUL2);
    cmd_o.base       = (state_q == S_BASE);
    cmd_o.load_row   = (state_q == S_ROW) && status_i.load_ok;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !in_command_i) state_d = S_PREP;
      end
      S_PREP: begin
        // newline and blank cells only move the cursor
        if (status_i.is_newline || status_i.is_skip) state_d = S_IDLE;
        else state_d = S_MUL1;
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_BASE;
      S_BASE: state_d = S_ROW;
      S_ROW: begin
        if (status_i.load_ok && status_i.row_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_print_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !in_command_i) |=> (state_q == S_PREP))
    else $error("print transfer did not start glyph preparation");

  a_no_glyph_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PREP && (status_i.is_newline || status_i.is_skip)) |=> (state_q == S_IDLE))
    else $error("newline or blank cell did not return to idle");

  a_font_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.font_write |=> (state_q == S_IDLE))
    else $error("font write left idle");

endmodule
`default_nettype wire

// File: hw/rtl/fbtc_datapath.sv
`default_nettype none
module fbtc_datapath import fbtc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_wdata_i,
  input  wire in_item_t             in_data_i,
  input  wire ctrl_cmd_t            cmd_i,
  output ctrl_status_t              status_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_data_o
);

  logic [1:0]  pixel_format_q;
  logic [31:0] frame_base_q;
  logic [15:0] line_pitch_q;
  logic [13:0] screen_width_q;
  logic [5:0]  glyph_height_q;
  logic [31:0] fg_color_q;
  logic [31:0] bg_color_q;

  logic [9:0]        col_q, col_d;
  logic [15:0]       row_q, row_d;
  logic [7:0]        code_q;
  logic [21:0]       line_q;
  logic [31:0]       prod_q;
  logic [31:0]       addr_q, addr_d;
  logic [GROW_W-1:0] grow_q, grow_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q;

  logic [5:0]        h_eff;
  logic [10:0]       cols;
  logic              wrap;
  logic [9:0]        col_w;
  logic [15:0]       row_w;
  logic [31:0]       prod_full;
  logic [12:0]       col_stride;
  logic [2:0]        stride;
  logic [31:0]       mask;
  logic [31:0]       fg;
  logic [31:0]       bg;
  logic              row_last;
  logic              ram_re;
  logic [GROW_W-1:0] rd_row;
  logic [7:0]        glyph_bits;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= RST_PIXEL_FORMAT;
      frame_base_q   <= RST_FRAME_BASE;
      line_pitch_q   <= RST_LINE_PITCH;
      screen_width_q <= RST_SCREEN_WIDTH;
      glyph_height_q <= RST_GLYPH_HEIGHT;
      fg_color_q     <= RST_FG_COLOR;
      bg_color_q     <= RST_BG_COLOR;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PIXEL_FORMAT: pixel_format_q <= cfg_wdata_i[1:0];
        CFG_FRAME_BASE:   frame_base_q   <= cfg_wdata_i;
        CFG_LINE_PITCH:   line_pitch_q   <= cfg_wdata_i[15:0];
        CFG_SCREEN_WIDTH: screen_width_q <= cfg_wdata_i[13:0];
        CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_wdata_i[5:0];
        CFG_FG_COLOR:     fg_color_q     <= cfg_wdata_i;
        CFG_BG_COLOR:     bg_color_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign h_eff = (glyph_height_q > 6'(MAX_GLYPH_ROWS)) ? 6'(MAX_GLYPH_ROWS) : glyph_height_q;
  assign cols  = screen_width_q[13:3];
  assign wrap  = ({1'b0, col_q} >= cols);
  assign col_w = wrap ? 10'd0 : col_q;
  assign row_w = wrap ? (row_q + 16'd1) : row_q;

  assign stride     = {1'b0, pixel_format_q} + 3'd1;
  assign col_stride = 13'(col_q) * 13'(stride);
  assign prod_full  = 32'(line_pitch_q) * 32'(line_q);

  always_comb begin
    unique case (pixel_format_q)
      PF_8:    mask = 32'h0000_00ff;
      PF_16:   mask = 32'h0000_ffff;
      PF_24:   mask = 32'h00ff_ffff;
      PF_32:   mask = 32'hffff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign fg       = fg_color_q & mask;
  assign bg       = bg_color_q & mask;
  assign row_last = (({1'b0, grow_q} + 6'd1) == h_eff);

  assign status_o.is_newline = (code_q == NEWLINE_CODE);
  assign status_o.is_skip    = code_q[7] || (h_eff == 6'd0);
  assign status_o.row_last   = row_last;
  assign status_o.load_ok    = !out_valid_q || !out_stall_i;

  // row 0 is fetched in the base cycle, the next row with every load
  assign ram_re = cmd_i.base || cmd_i.load_row;
  assign rd_row = cmd_i.base ? '0 : grow_q + GROW_W'(1);

  fbtc_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_font_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.font_write),
    .waddr_i(in_data_i.font_address[FONT_AW-1:0]),
    .wdata_i(in_data_i.font_byte),
    .re_i   (ram_re),
    .raddr_i({code_q[CODE_W-1:0], rd_row}),
    .rdata_o(glyph_bits)
  );

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    addr_d = addr_q;
    grow_d = grow_q;
    if (cmd_i.prep) begin
      if (status_o.is_newline) begin
        row_d = row_w + 16'd1;
        col_d = 10'd0;
      end else if (status_o.is_skip) begin
        row_d = row_w;
        col_d = col_w + 10'd1;
      end else begin
        row_d = row_w;
        col_d = col_w;
      end
    end
    if (cmd_i.base) begin
      addr_d = frame_base_q + prod_q + {16'd0, col_stride, 3'd0};
      grow_d = '0;
    end
    if (cmd_i.load_row) begin
      addr_d = addr_q + {16'd0, line_pitch_q};
      grow_d = grow_q + GROW_W'(1);
      if (row_last) col_d = col_q + 10'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_row) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      grow_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      grow_q      <= grow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) code_q <= in_data_i.char_code;
    if (cmd_i.mul_line) line_q <= 22'(row_q) * 22'(h_eff);
    if (cmd_i.mul_pitch) prod_q <= prod_full;
    addr_q <= addr_d;
    if (cmd_i.load_row) begin
      out_q.row_address <= addr_q;
      out_q.pixel_0     <= glyph_bits[7] ? fg : bg;
      out_q.pixel_1     <= glyph_bits[6] ? fg : bg;
      out_q.pixel_2     <= glyph_bits[5] ? fg : bg;
      out_q.pixel_3     <= glyph_bits[4] ? fg : bg;
      out_q.pixel_4     <= glyph_bits[3] ? fg : bg;
      out_q.pixel_5     <= glyph_bits[2] ? fg : bg;
      out_q.pixel_6     <= glyph_bits[1] ? fg : bg;
      out_q.pixel_7     <= glyph_bits[0] ? fg : bg;
      out_q.last_row    <= row_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_row |-> ({1'b0, grow_q} < h_eff))
    else $error("glyph row beyond glyph height");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_row && row_last) |=> (col_q == $past(col_q) + 10'd1))
    else $error("cursor did not advance after final glyph row");

endmodule
`default_nettype wire

// File: hw/rtl/bitmap_font_text_console_top.sv
// font write: accepted from idle; newline, ignored code or zero glyph height: prep, idle
// printable glyph: prep, mul1, mul2, base, then a row loop, rows = min(glyph_height, 32)
// the row loop emits one row per cycle, unless the output stalls, from the font ram's
// registered read port; the first row is registered at the output by the first row load
// async active-low reset: registers to defaults, cursor to 0, font ram undefined
`default_nettype none
module bitmap_font_text_console_top import fbtc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_item_t                 out_data_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  fbtc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_command_i(in_data_i.command),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fbtc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// File: verif/bitmap_font_text_console_checker.sv
module bitmap_font_text_console_checker import fbtc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_wdata_i,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire in_item_t             in_data_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire out_item_t            out_data_i,
  output int                        mismatches_o,
  output int                        rows_pending_o
);

  typedef logic [GLYPH_WIDTH-1:0][31:0] row_pixels_t;

  logic [1:0]  pix_fmt;
  logic [31:0] fb_base;
  logic [15:0] pitch;
  logic [13:0] scr_width;
  logic [5:0]  glyph_rows;
  logic [31:0] fg_px;
  logic [31:0] bg_px;
  logic [9:0]  cur_col;
  logic [15:0] cur_row;
  logic [7:0]  glyphs [STORE_DEPTH];

  out_item_t   rows_due [$];
  out_item_t   want;
  row_pixels_t want_px;
  row_pixels_t got_px;
  int          mismatch_cnt = 0;

  // element GLYPH_WIDTH-1 holds the leftmost pixel
  function automatic row_pixels_t pixels_of(input out_item_t r);
    return {r.pixel_0, r.pixel_1, r.pixel_2, r.pixel_3,
            r.pixel_4, r.pixel_5, r.pixel_6, r.pixel_7};
  endfunction

  task automatic render_item(input in_item_t it);
    int unsigned cols;
    int unsigned h;
    int unsigned stride;
    int unsigned r;
    int unsigned k;
    logic [31:0] mask;
    logic [7:0]  bits;
    logic [63:0] line;
    logic [63:0] addr;
    row_pixels_t px;
    if (it.command) begin
      glyphs[it.font_address % STORE_DEPTH] = it.font_byte;
      return;
    end
    // wrap check comes first, newline and ignored codes included
    cols = scr_width / GLYPH_WIDTH;
    if (cur_col >= cols) begin
      cur_row = cur_row + 16'd1;
      cur_col = '0;
    end
    if (it.char_code == NEWLINE_CODE) begin
      cur_row = cur_row + 16'd1;
      cur_col = '0;
      return;
    end
    if (it.char_code < 8'h80) begin
      h = (glyph_rows > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS : glyph_rows;
      stride = pix_fmt + 1;
      case (pix_fmt)
        PF_8:    mask = 32'h0000_00ff;
        PF_16:   mask = 32'h0000_ffff;
        PF_24:   mask = 32'h00ff_ffff;
        default: mask = 32'hffff_ffff;
      endcase
      for (r = 0; r < h; r++) begin
        bits = glyphs[(it.char_code * MAX_GLYPH_ROWS + r) % STORE_DEPTH];
        for (k = 0; k < GLYPH_WIDTH; k++)
          px[k] = bits[k] ? (fg_px & mask) : (bg_px & mask);
        line = 64'(cur_row) * h + r;
        addr = 64'(fb_base) + 64'(pitch) * line + 64'(cur_col) * GLYPH_WIDTH * stride;
        rows_due.push_back({addr[31:0], px, (r + 1 == h)});
      end
    end
    cur_col = cur_col + 10'd1;
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_fmt    = RST_PIXEL_FORMAT;
      fb_base    = RST_FRAME_BASE;
      pitch      = RST_LINE_PITCH;
      scr_width  = RST_SCREEN_WIDTH;
      glyph_rows = RST_GLYPH_HEIGHT;
      fg_px      = RST_FG_COLOR;
      bg_px      = RST_BG_COLOR;
      cur_col    = '0;
      cur_row    = '0;
      rows_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rows_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected row transfer at address %h", out_data_i.row_address);
        end else begin
          want = rows_due.pop_front();
          want_px = pixels_of(want);
          got_px = pixels_of(out_data_i);
          check_field("row_address", want.row_address, out_data_i.row_address);
          for (int x = 0; x < GLYPH_WIDTH; x++)
            check_field($sformatf("pixel_%0d", x), want_px[GLYPH_WIDTH-1-x],
                        got_px[GLYPH_WIDTH-1-x]);
          check_field("last_row", 32'(want.last_row), 32'(out_data_i.last_row));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PIXEL_FORMAT: pix_fmt    = cfg_wdata_i[1:0];
          CFG_FRAME_BASE:   fb_base    = cfg_wdata_i;
          CFG_LINE_PITCH:   pitch      = cfg_wdata_i[15:0];
          CFG_SCREEN_WIDTH: scr_width  = cfg_wdata_i[13:0];
          CFG_GLYPH_HEIGHT: glyph_rows = cfg_wdata_i[5:0];
          CFG_FG_COLOR:     fg_px      = cfg_wdata_i;
          CFG_BG_COLOR:     bg_px      = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        render_item(in_data_i);
    end
    mismatches_o = mismatch_cnt;
    rows_pending_o = rows_due.size();
  end

endmodule

// File: verif/tb_bitmap_font_text_console_top.sv
module tb_bitmap_font_text_console_top;
  import fbtc_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS   = 30;
  localparam int unsigned PHASES        = 6;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PIXEL_FORMAT;
  logic [31:0]          cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  int                   mismatches;
  int                   rows_pending;

  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned eff_height = RST_GLYPH_HEIGHT;
  int unsigned items_sent = 0;
  bit          font_known [STORE_DEPTH];
  bit          glyph_seen [GLYPH_COUNT];
  logic [7:0]  loaded_codes [$];

  bitmap_font_text_console_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  bitmap_font_text_console_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .mismatches_o   (mismatches),
    .rows_pending_o (rows_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly no gap, some short ones, a rare long one
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left == 0) stall_left = gap_len();
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input in_item_t it);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic font_write(input logic [11:0] addr, input logic [7:0] value);
    in_item_t it;
    it.command      = 1'b1;
    it.char_code    = 8'($urandom);
    it.font_address = addr;
    it.font_byte    = value;
    send(it);
    font_known[addr] = 1'b1;
  endtask

  // never print a glyph row that was not loaded yet
  task automatic ensure_glyph(input logic [6:0] code);
    logic [11:0] a;
    for (int unsigned r = 0; r < eff_height; r++) begin
      a = 12'(code * MAX_GLYPH_ROWS + r);
      if (!font_known[a]) font_write(a, 8'($urandom));
    end
    if (!glyph_seen[code]) begin
      glyph_seen[code] = 1'b1;
      loaded_codes.push_back({1'b0, code});
    end
  endtask

  task automatic print_char(input logic [7:0] code);
    in_item_t it;
    if (code < 8'h80 && code != NEWLINE_CODE) ensure_glyph(code[6:0]);
    it.command      = 1'b0;
    it.char_code    = code;
    it.font_address = 12'($urandom);
    it.font_byte    = 8'($urandom);
    send(it);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic configure(input logic [1:0] pf, input logic [31:0] base,
                           input logic [15:0] pitch, input logic [13:0] width,
                           input logic [5:0] height, input logic [31:0] fg,
                           input logic [31:0] bg);
    settle();
    set_reg(CFG_PIXEL_FORMAT, 32'(pf));
    set_reg(CFG_FRAME_BASE, base);
    set_reg(CFG_LINE_PITCH, 32'(pitch));
    set_reg(CFG_SCREEN_WIDTH, 32'(width));
    set_reg(CFG_GLYPH_HEIGHT, 32'(height));
    set_reg(CFG_FG_COLOR, fg);
    set_reg(CFG_BG_COLOR, bg);
    cfg_we <= 1'b0;
    @(negedge clk);
    eff_height = (height > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS : height;
  endtask

  task automatic random_config();
    logic [13:0] width;
    logic [5:0]  height;
    logic [15:0] pitch;
    logic [31:0] base;
    case ($urandom_range(0, 5))
      0:       width = 14'($urandom_range(0, 7));
      1:       width = 14'd8;
      2:       width = 14'h3fff;
      default: width = 14'($urandom_range(16, 256));
    endcase
    case ($urandom_range(0, 5))
      0:       height = 6'd0;
      1:       height = 6'(MAX_GLYPH_ROWS);
      2:       height = 6'($urandom_range(33, 63));
      default: height = 6'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 3))
      0:       pitch = 16'h0000;
      1:       pitch = 16'hffff;
      default: pitch = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       base = 32'h0000_0000;
      1:       base = 32'hffff_ffff;
      default: base = $urandom;
    endcase
    configure(2'($urandom), base, pitch, width, height, $urandom, $urandom);
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned start;
    logic [7:0]  code;
    start = items_sent;
    while (items_sent - start < count) begin
      code = 8'($urandom_range(0, 127));
      if (code == NEWLINE_CODE) code = 8'd0;
      case ($urandom_range(0, 9))
        0, 1: begin
          // fresh glyph content, then a few prints of it
          for (int unsigned r = 0; r < eff_height; r++)
            font_write(12'(code * MAX_GLYPH_ROWS + r), 8'($urandom));
          repeat ($urandom_range(1, 3)) print_char(code);
        end
        2, 3: print_char(code);
        4, 5: begin
          if (loaded_codes.size() != 0)
            code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
          print_char(code);
        end
        6:       print_char(NEWLINE_CODE);
        7:       print_char(8'($urandom_range(128, 255)));
        8:       font_write(12'($urandom), 8'($urandom));
        default: repeat ($urandom_range(2, 6)) print_char(code);
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, extreme glyph rows
    font_write(12'(8'h41 * MAX_GLYPH_ROWS + 0), 8'hff);
    font_write(12'(8'h41 * MAX_GLYPH_ROWS + 1), 8'h00);
    font_write(12'(8'h41 * MAX_GLYPH_ROWS + 2), 8'h80);
    font_write(12'(8'h41 * MAX_GLYPH_ROWS + 3), 8'h01);
    font_write(12'(8'h41 * MAX_GLYPH_ROWS + 4), 8'haa);
    font_write(12'(8'h41 * MAX_GLYPH_ROWS + 5), 8'h55);
    font_write(12'hfff, 8'hff);
    print_char(8'h41);
    print_char(8'h00);
    print_char(NEWLINE_CODE);
    print_char(8'h80);
    print_char(8'hff);
    print_char(8'h41);

    // one column per line, single-row glyphs, top of address space
    configure(PF_8, 32'hffff_ffff, 16'hffff, 14'd8, 6'd1, 32'hffff_ffff, 32'h0);
    print_char(8'h41);
    print_char(8'h41);
    print_char(8'h00);

    // narrow screen with zero glyph height
    configure(PF_16, 32'h0, 16'h0, 14'd0, 6'd0, 32'h1234_5678, 32'h9abc_def0);
    print_char(8'h41);
    print_char(8'h41);
    print_char(NEWLINE_CODE);
    print_char(8'h7f);

    // widest screen, glyph height saturates
    configure(PF_24, 32'h8000_0000, 16'h1234, 14'h3fff, 6'h3f, 32'ha5a5_a5a5,
              32'h5a5a_5a5a);
    print_char(8'h7f);
    print_char(8'h41);

    configure(PF_32, 32'h0010_0000, 16'd4096, 14'd24, 6'd32, $urandom, $urandom);
    print_char(8'h41);
    print_char(8'h00);
    print_char(8'h7f);
    print_char(8'h41);

    for (int unsigned p = 0; p < PHASES; p++) begin
      random_config();
      calm = ($urandom_range(0, 3) == 0);
      random_traffic(PHASE_ITEMS);
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0 && rows_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
